// ===== design/ngsc_pkg.sv =====
// Shared types, constants and helpers for the nearest-gap steering control block.
// No dependencies; used by nearest_gap_steering_control_unit.
`timescale 1ns / 1ps

package ngsc_pkg;

  // Field widths
  localparam int unsigned XW     = 9;   // centroid column
  localparam int unsigned YW     = 8;   // centroid row
  localparam int unsigned DISTW  = 17;  // squared distance
  localparam int unsigned GAINW  = 12;  // Q4.8 gain
  localparam int unsigned LIMW   = 8;
  localparam int unsigned BASEW  = 8;
  localparam int unsigned SPDW   = 19;  // Q.8 wheel speed
  localparam int unsigned SERRW  = 8;   // reported steer error
  localparam int unsigned ERRW   = 10;  // internal error, -130..125
  localparam int unsigned STEERW = GAINW + 1 + ERRW;  // signed gain * error
  localparam int unsigned WIDEW  = STEERW + 1;        // speed before saturation
  localparam int unsigned CFGW   = 12;
  localparam int unsigned IDXW   = 2;
  localparam int unsigned IN_TDATAW  = 24;
  localparam int unsigned OUT_TDATAW = 48;

  // Geometry
  localparam logic [XW-1:0] ROBOT_X         = 9'd250;
  localparam logic [YW-1:0] ROBOT_Y         = 8'd250;
  localparam logic [XW-1:0] RIGHT_DEFAULT_X = 9'd500;

  // Register reset values
  localparam logic [GAINW-1:0] GAIN_RST  = 12'd256;
  localparam logic             EN_RST    = 1'b0;
  localparam logic [LIMW-1:0]  LIMIT_RST = 8'd60;
  localparam logic [BASEW-1:0] BASE_RST  = 8'd50;

  // Register map
  typedef enum logic [IDXW-1:0] {
    REG_STEER_GAIN   = 2'd0,
    REG_DRIVE_ENABLE = 2'd1,
    REG_ERROR_LIMIT  = 2'd2,
    REG_BASE_SPEED   = 2'd3
  } cfg_reg_e;

  // Saturate a wide signed speed into the 19 bit Q.8 range
  function automatic logic signed [SPDW-1:0] sat_speed(input logic signed [WIDEW-1:0] v);
    logic signed [WIDEW-1:0] hi;
    logic signed [WIDEW-1:0] lo;
    hi = WIDEW'(signed'({1'b0, {(SPDW-1){1'b1}}}));
    lo = -hi - WIDEW'(1);
    if (v > hi) begin
      sat_speed = hi[SPDW-1:0];
    end else if (v < lo) begin
      sat_speed = lo[SPDW-1:0];
    end else begin
      sat_speed = v[SPDW-1:0];
    end
  endfunction

  // Clamp internal error to the 8 bit reported range
  function automatic logic signed [SERRW-1:0] sat_err(input logic signed [ERRW-1:0] e);
    if (e > ERRW'(127)) begin
      sat_err = 8'sd127;
    end else if (e < -ERRW'(128)) begin
      sat_err = -8'sd128;
    end else begin
      sat_err = e[SERRW-1:0];
    end
  endfunction

endpackage

// ===== design/nearest_gap_steering_control_unit.sv =====
// Nearest-gap steering control: per-frame nearest left/right object to wheel speeds.
// Depends on ngsc_pkg for widths, register map and saturation helpers.
`timescale 1ns / 1ps
// A frame_end beat passes the input, distance, error and output registers to m_axis.
// Throughput: one beat per cycle unless back-pressure holds a frame_end beat; the input
// register, distance stage, error stage and output register each hold one beat and
// advance independently, so bubbles fill while a result waits on m_axis_tready.
// Reset (rst_ni low, async): pipeline empty, nearest-object state cleared,
// registers back to gain 1.0, disabled, limit 60, base speed 50.

module nearest_gap_steering_control_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write port
  input  logic                              cfg_we_i,
  input  logic [ngsc_pkg::IDXW-1:0]         cfg_idx_i,
  input  logic [ngsc_pkg::CFGW-1:0]         cfg_data_i,
  // centroid stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ngsc_pkg::IN_TDATAW-1:0]    s_axis_tdata,   // obj_x[8:0], obj_y[16:9], zero pad
  input  logic                              s_axis_tuser,   // obj_present
  input  logic                              s_axis_tlast,   // frame_end
  // speed stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [ngsc_pkg::OUT_TDATAW-1:0]   m_axis_tdata    // left_speed[18:0],
                                                            // right_speed[37:19],
                                                            // steer_error[45:38],
                                                            // left_found[46],
                                                            // right_found[47]
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ngsc_pkg::GAINW-1:0] gain_q;
  logic                       en_q;
  logic [ngsc_pkg::LIMW-1:0]  limit_q;
  logic [ngsc_pkg::BASEW-1:0] base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= ngsc_pkg::GAIN_RST;
      en_q    <= ngsc_pkg::EN_RST;
      limit_q <= ngsc_pkg::LIMIT_RST;
      base_q  <= ngsc_pkg::BASE_RST;
    end else if (cfg_we_i) begin
      unique case (ngsc_pkg::cfg_reg_e'(cfg_idx_i))
        ngsc_pkg::REG_STEER_GAIN:   gain_q  <= cfg_data_i;
        ngsc_pkg::REG_DRIVE_ENABLE: en_q    <= cfg_data_i[0];
        ngsc_pkg::REG_ERROR_LIMIT:  limit_q <= cfg_data_i[ngsc_pkg::LIMW-1:0];
        ngsc_pkg::REG_BASE_SPEED:   base_q  <= cfg_data_i[ngsc_pkg::BASEW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake chain: each stage loads when it is empty or drains this cycle
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, ov_q;
  logic fe2_q;
  logic ld_out, ld3, ld2, ld1;
  logic fire3, fire2, fire1, acc;

  assign ld_out = !ov_q || m_axis_tready;
  assign fire3  = v3_q && ld_out;
  assign ld3    = !v3_q || fire3;
  // only frame_end beats move on to the error stage; others retire in stage 2
  assign fire2  = v2_q && (!fe2_q || ld3);
  assign ld2    = !v2_q || fire2;
  assign fire1  = v1_q && ld2;
  assign ld1    = !v1_q || fire1;

  assign s_axis_tready = ld1;
  assign acc           = s_axis_tvalid && ld1;

  // ---------------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------------
  logic [ngsc_pkg::XW-1:0] x1_q;
  logic [ngsc_pkg::YW-1:0] y1_q;
  logic                    p1_q, fe1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (ld1) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      x1_q  <= s_axis_tdata[ngsc_pkg::XW-1:0];
      y1_q  <= s_axis_tdata[ngsc_pkg::XW +: ngsc_pkg::YW];
      p1_q  <= s_axis_tuser;
      fe1_q <= s_axis_tlast;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 -> 2: squared distance to the robot point
  // ---------------------------------------------------------------------------
  logic signed [ngsc_pkg::XW:0]   dx;
  logic signed [ngsc_pkg::YW+1:0] dy;
  logic [ngsc_pkg::XW-1:0]        adx;
  logic [ngsc_pkg::YW-1:0]        ady;
  logic [2*ngsc_pkg::XW:0]        dsum;
  logic [ngsc_pkg::DISTW-1:0]     dist1;

  always_comb begin
    dx    = signed'({1'b0, ngsc_pkg::ROBOT_X}) - signed'({1'b0, x1_q});
    dy    = signed'({2'b0, ngsc_pkg::ROBOT_Y}) - signed'({2'b0, y1_q});
    adx   = dx[ngsc_pkg::XW] ? ngsc_pkg::XW'(-dx) : dx[ngsc_pkg::XW-1:0];
    ady   = dy[ngsc_pkg::YW+1] ? ngsc_pkg::YW'(-dy) : dy[ngsc_pkg::YW-1:0];
    dsum  = (2*ngsc_pkg::XW+1)'(adx * adx) + (2*ngsc_pkg::XW+1)'(ady * ady);
    dist1 = dsum[ngsc_pkg::DISTW-1:0];
  end

  // ---------------------------------------------------------------------------
  // Stage 2: distance register, nearest-object update
  // ---------------------------------------------------------------------------
  logic [ngsc_pkg::XW-1:0]    x2_q;
  logic [ngsc_pkg::DISTW-1:0] dist2_q;
  logic                       p2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (ld2) begin
      v2_q <= fire1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire1) begin
      x2_q    <= x1_q;
      dist2_q <= dist1;
      p2_q    <= p1_q;
      fe2_q   <= fe1_q;
    end
  end

  // nearest-object state
  logic [ngsc_pkg::DISTW-1:0] lbd_q, rbd_q;
  logic [ngsc_pkg::XW-2:0]    lbx_q;
  logic [ngsc_pkg::XW-1:0]    rbx_q;
  logic                       lv_q, rv_q;

  logic                       is_left, take_l, take_r;
  logic                       nlv, nrv;
  logic [ngsc_pkg::XW-2:0]    nlx;
  logic [ngsc_pkg::XW-1:0]    nrx;
  logic [ngsc_pkg::XW-1:0]    lx, rx;
  logic [ngsc_pkg::XW:0]      xsum;
  logic signed [ngsc_pkg::ERRW-1:0] err2;

  always_comb begin
    is_left = x2_q < ngsc_pkg::ROBOT_X;
    // strict less-than: earlier object keeps a tie
    take_l  = p2_q && is_left && (!lv_q || (dist2_q < lbd_q));
    take_r  = p2_q && !is_left && (!rv_q || (dist2_q < rbd_q));
    nlv     = lv_q || take_l;
    nrv     = rv_q || take_r;
    nlx     = take_l ? x2_q[ngsc_pkg::XW-2:0] : lbx_q;
    nrx     = take_r ? x2_q : rbx_q;
    // missing sides fall back to the frame edges
    lx      = nlv ? {1'b0, nlx} : '0;
    rx      = nrv ? nrx : ngsc_pkg::RIGHT_DEFAULT_X;
    xsum    = {1'b0, lx} + {1'b0, rx};
    err2    = signed'(ngsc_pkg::ERRW'(ngsc_pkg::ROBOT_X))
            - signed'(ngsc_pkg::ERRW'(xsum[ngsc_pkg::XW:1]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lbd_q <= '0;
      lbx_q <= '0;
      lv_q  <= 1'b0;
      rbd_q <= '0;
      rbx_q <= '0;
      rv_q  <= 1'b0;
    end else if (fire2) begin
      if (take_l) begin
        lbd_q <= dist2_q;
        lbx_q <= nlx;
      end
      if (take_r) begin
        rbd_q <= dist2_q;
        rbx_q <= nrx;
      end
      // frame end starts a fresh frame
      lv_q <= nlv && !fe2_q;
      rv_q <= nrv && !fe2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: error register, P-steering
  // ---------------------------------------------------------------------------
  logic signed [ngsc_pkg::ERRW-1:0] err3_q;
  logic                             lf3_q, rf3_q;
  logic                             load3;

  assign load3 = fire2 && fe2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (ld3) begin
      v3_q <= load3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load3) begin
      err3_q <= err2;
      lf3_q  <= nlv;
      rf3_q  <= nrv;
    end
  end

  logic [ngsc_pkg::ERRW-1:0]           mag;
  logic                                straight;
  logic signed [ngsc_pkg::STEERW-1:0]  steer;
  logic signed [ngsc_pkg::WIDEW-1:0]   base_w, ls_w, rs_w;
  logic signed [ngsc_pkg::SPDW-1:0]    ls_d, rs_d;

  always_comb begin
    mag      = err3_q[ngsc_pkg::ERRW-1] ? ngsc_pkg::ERRW'(-err3_q) : ngsc_pkg::ERRW'(err3_q);
    straight = (err3_q == '0) || (mag > ngsc_pkg::ERRW'(limit_q));
    steer    = signed'({1'b0, gain_q}) * err3_q;
    base_w   = signed'(ngsc_pkg::WIDEW'({base_q, 8'd0}));
    if (!en_q) begin
      ls_w = '0;
      rs_w = '0;
    end else if (straight) begin
      ls_w = base_w;
      rs_w = -base_w;
    end else begin
      ls_w = base_w - ngsc_pkg::WIDEW'(steer);
      rs_w = -(base_w + ngsc_pkg::WIDEW'(steer));
    end
    ls_d = ngsc_pkg::sat_speed(ls_w);
    rs_d = ngsc_pkg::sat_speed(rs_w);
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic signed [ngsc_pkg::SPDW-1:0]  ls_q, rs_q;
  logic signed [ngsc_pkg::SERRW-1:0] se_q;
  logic                              lf_q, rf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (ld_out) begin
      ov_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire3) begin
      ls_q <= ls_d;
      rs_q <= rs_d;
      se_q <= ngsc_pkg::sat_err(err3_q);
      lf_q <= lf3_q;
      rf_q <= rf3_q;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {rf_q, lf_q, se_q, rs_q, ls_q};

endmodule
